>>> design/assert_macros.svh
// assertion macros shared by the snoop ordering design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define SODIST_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define SODIST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sodist_pkg.sv
// package: types, constants and coordinate helpers for snoop ordering
package sodist_pkg;

    localparam int NODE_COUNT = 16;
    localparam int NODE_W     = 4;
    // rows and columns stay below 8 for every supported mesh width
    localparam int COORD_W    = 3;
    localparam int KEY_W      = 5;
    // largest key: two distances of at most 8 hops each
    localparam logic [KEY_W-1:0] KEY_MAX = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN
    } t_state;

    // control shared by the top level with every lane
    typedef struct packed {
        logic               load;
        logic               three;
        logic               mcast;
        logic [COORD_W-1:0] src_row;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] fin_row;
        logic [COORD_W-1:0] fin_col;
        logic [KEY_W-1:0]   scan_key;
    } t_lane_ctl;

    // row of a node: independent range compares, no divider
    function automatic logic [COORD_W-1:0] node_row(input logic [NODE_W-1:0] node,
                                                    input int w);
        logic [COORD_W-1:0] row;
        row = '0;
        for (int r = 0; r < NODE_COUNT; r++) begin
            if (int'(node) >= r * w && int'(node) < (r + 1) * w) begin
                row = COORD_W'(r);
            end
        end
        return row;
    endfunction

    // column of a node: id less row times width
    function automatic logic [COORD_W-1:0] node_col(input logic [NODE_W-1:0] node,
                                                    input int w);
        return COORD_W'(int'(node) - int'(node_row(node, w)) * w);
    endfunction

endpackage

>>> design/sodist_if.sv
// handshake interfaces for request and snoop result channels
interface sodist_req_if import sodist_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_COUNT-1:0] sharer_mask;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] final_node;
    logic              three_hop_mode;
    logic              multicast_mode;

    modport source (output valid, sharer_mask, source_node, final_node,
                    three_hop_mode, multicast_mode, input ready);
    modport sink   (input valid, sharer_mask, source_node, final_node,
                    three_hop_mode, multicast_mode, output ready);
endinterface

interface sodist_snp_if import sodist_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_id;
    logic              last;

    modport source (output valid, node_id, last, input ready);
    modport sink   (input valid, node_id, last, output ready);
endinterface

>>> design/sodist_lane.sv
// one lane: distance key and pending flag for a single mesh node
module sodist_lane import sodist_pkg::*; #(
    parameter int NODE       = 0,
    parameter int MESH_WIDTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  logic      i_mask_bit,
    input  logic      i_grant,
    output logic      o_match,
    output logic      o_pend
);

    localparam logic [COORD_W-1:0] ROW = COORD_W'(NODE / MESH_WIDTH);
    localparam logic [COORD_W-1:0] COL = COORD_W'(NODE % MESH_WIDTH);

    logic [KEY_W-1:0]   r_key;
    logic               r_pend;
    logic [COORD_W-1:0] w_dr_src;
    logic [COORD_W-1:0] w_dc_src;
    logic [COORD_W-1:0] w_dr_fin;
    logic [COORD_W-1:0] w_dc_fin;
    logic [KEY_W-1:0]   n_key;

    // absolute coordinate differences to source and final node
    always_comb begin
        w_dr_src = (ROW > i_ctl.src_row) ? ROW - i_ctl.src_row : i_ctl.src_row - ROW;
        w_dc_src = (COL > i_ctl.src_col) ? COL - i_ctl.src_col : i_ctl.src_col - COL;
        w_dr_fin = (ROW > i_ctl.fin_row) ? ROW - i_ctl.fin_row : i_ctl.fin_row - ROW;
        w_dc_fin = (COL > i_ctl.fin_col) ? COL - i_ctl.fin_col : i_ctl.fin_col - COL;
    end

    // key; multicast puts every node on key zero so ids come out ascending
    always_comb begin
        n_key = KEY_W'(w_dr_src) + KEY_W'(w_dc_src);
        if (i_ctl.three) begin
            n_key = n_key + KEY_W'(w_dr_fin) + KEY_W'(w_dc_fin);
        end
        if (i_ctl.mcast) begin
            n_key = '0;
        end
    end

    // pending flag: set from the mask at load, cleared when granted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_ctl.load) begin
            r_pend <= i_mask_bit;
        end else if (i_grant) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= n_key;
        end
    end

    assign o_match = r_pend && (r_key == i_ctl.scan_key);
    assign o_pend  = r_pend;

endmodule

>>> design/sodist_pick.sv
// merge stage: lowest matching node id wins the output slot
module sodist_pick import sodist_pkg::*; (
    input  logic [NODE_COUNT-1:0] i_match,
    output logic [NODE_COUNT-1:0] o_grant,
    output logic [NODE_W-1:0]     o_id,
    output logic                  o_any
);

    // priority encode from the top down so the lowest id is kept
    always_comb begin
        o_id = '0;
        for (int i = NODE_COUNT - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_id = NODE_W'(i);
            end
        end
    end

    assign o_any   = |i_match;
    assign o_grant = o_any ? (NODE_COUNT'(1) << o_id) : '0;

endmodule

>>> design/snoop_order_by_mesh_distance_unit.sv
// top level: orders the sharers of one request by mesh distance
//
// Request channel i_req carries a sharer mask, source and final node and
// two mode flags; result channel o_snp returns one sharer id per
// transaction, with last set on the final one of the request. A request
// with an empty mask is taken and gives no result.
// Sixteen lanes, one per node, register each sharer's key in the cycle
// after acceptance. A key counter then walks upwards from zero; at each key
// value the lowest pending id whose key matches is sent, and the counter
// moves on only when no pending lane matches. The scan ends once no lane
// is pending, so an empty mask passes through load and scan back to idle.
// The first result is registered in the scan state at the earliest, after
// the load state that follows acceptance. A new request is taken once the
// last result of the previous one sits in the output register. A stalled
// receiver holds the output register and the scan waits with it. Reset
// empties the output register, returns to idle and holds the request
// channel not ready.
`include "assert_macros.svh"

module snoop_order_by_mesh_distance_unit import sodist_pkg::*; #(
    parameter int MESH_WIDTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sodist_req_if.sink   i_req,
    sodist_snp_if.source o_snp
);

    t_state                r_state;
    t_state                n_state;
    logic                  r_three;
    logic                  r_mcast;
    logic [NODE_COUNT-1:0] r_mask;
    logic [COORD_W-1:0]    r_src_row;
    logic [COORD_W-1:0]    r_src_col;
    logic [COORD_W-1:0]    r_fin_row;
    logic [COORD_W-1:0]    r_fin_col;
    logic [KEY_W-1:0]      r_scan;
    logic                  r_out_valid;
    logic [NODE_W-1:0]     r_out_id;
    logic                  r_out_last;

    t_lane_ctl             w_ctl;
    logic [NODE_COUNT-1:0] w_match;
    logic [NODE_COUNT-1:0] w_pend;
    logic [NODE_COUNT-1:0] w_grant;
    logic [NODE_W-1:0]     w_id;
    logic                  w_any;
    logic                  w_accept;
    logic                  w_slot;
    logic                  w_emit;
    logic                  w_last;

    assign i_req.ready = (r_state == ST_IDLE) && i_rst_n;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot      = !r_out_valid || o_snp.ready;
    assign w_emit      = (r_state == ST_SCAN) && w_any && w_slot;
    assign w_last      = ((w_pend & ~w_grant) == '0);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_pend == '0 || (w_emit && w_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // request capture with source and final coordinates
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mask    <= i_req.sharer_mask;
            r_three   <= i_req.three_hop_mode;
            r_mcast   <= i_req.multicast_mode;
            r_src_row <= node_row(i_req.source_node, MESH_WIDTH);
            r_src_col <= node_col(i_req.source_node, MESH_WIDTH);
            r_fin_row <= node_row(i_req.final_node, MESH_WIDTH);
            r_fin_col <= node_col(i_req.final_node, MESH_WIDTH);
        end
    end

    // key counter: restarts at load, steps when no pending lane matches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (r_state == ST_LOAD) begin
            r_scan <= '0;
        end else if (r_state == ST_SCAN && !w_any && w_pend != '0) begin
            r_scan <= r_scan + 1'b1;
        end
    end

    always_comb begin
        w_ctl.load     = (r_state == ST_LOAD);
        w_ctl.three    = r_three;
        w_ctl.mcast    = r_mcast;
        w_ctl.src_row  = r_src_row;
        w_ctl.src_col  = r_src_col;
        w_ctl.fin_row  = r_fin_row;
        w_ctl.fin_col  = r_fin_col;
        w_ctl.scan_key = r_scan;
    end

    // one lane per node
    for (genvar g = 0; g < NODE_COUNT; g++) begin : g_lane
        sodist_lane #(
            .NODE       (g),
            .MESH_WIDTH (MESH_WIDTH)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_mask_bit (r_mask[g]),
            .i_grant    (w_grant[g] && w_emit),
            .o_match    (w_match[g]),
            .o_pend     (w_pend[g])
        );
    end

    sodist_pick u_pick (
        .i_match (w_match),
        .o_grant (w_grant),
        .o_id    (w_id),
        .o_any   (w_any)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_snp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_id   <= w_id;
            r_out_last <= w_last;
        end
    end

    assign o_snp.valid   = r_out_valid;
    assign o_snp.node_id = r_out_id;
    assign o_snp.last    = r_out_last;

    // checks
    `SODIST_ASSERT_RST(a_grant_onehot, i_clk, i_rst_n, $onehot0(w_grant), "grant not one-hot")
    `SODIST_ASSERT_RST(a_last_to_idle, i_clk, i_rst_n, (w_emit && w_last) |=> (r_state == ST_IDLE), "no idle after last transaction")
    `SODIST_ASSERT_RST(a_scan_range, i_clk, i_rst_n, (r_state == ST_SCAN) |-> (r_scan <= KEY_MAX), "key counter overran")
    `SODIST_ASSERT_ALWAYS(a_emit_slot, i_clk, w_emit |-> w_slot, "result sent into a full output register")

endmodule

>>> tb/sv/snoop_order_checker.sv
// checker: predicts the snoop order of each request and compares the result channel
module snoop_order_checker import sodist_pkg::*; #(
    parameter int MESH_WIDTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [NODE_COUNT-1:0] i_req_sharer_mask,
    input  logic [NODE_W-1:0]     i_req_source_node,
    input  logic [NODE_W-1:0]     i_req_final_node,
    input  logic                  i_req_three_hop_mode,
    input  logic                  i_req_multicast_mode,
    input  logic                  i_snp_valid,
    input  logic                  i_snp_ready,
    input  logic [NODE_W-1:0]     i_snp_node_id,
    input  logic                  i_snp_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int OWED_DEPTH = 64;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic              last;
    } t_snoop;

    // snoops still owed by the block, oldest at the head
    t_snoop owed_buf[OWED_DEPTH];
    int     owed_head;
    int     owed_tail;

    // hop count between two nodes, row-major placement
    function automatic int mesh_hops(input int p, input int q);
        int dr;
        int dc;
        dr = p / MESH_WIDTH - q / MESH_WIDTH;
        dc = p % MESH_WIDTH - q % MESH_WIDTH;
        if (dr < 0) dr = -dr;
        if (dc < 0) dc = -dc;
        return dr + dc;
    endfunction

    // work out the order in which the sharers of one request are snooped
    task automatic predict_snoop_order(input logic [NODE_COUNT-1:0] mask,
                                       input logic [NODE_W-1:0] src,
                                       input logic [NODE_W-1:0] fin,
                                       input logic three,
                                       input logic mcast);
        int     node_key[NODE_COUNT];
        int     order[NODE_COUNT];
        int     sharers;
        int     placed;
        t_snoop s;
        sharers = 0;
        placed  = 0;
        for (int i = 0; i < NODE_COUNT; i++) begin
            node_key[i] = mesh_hops(int'(src), i) + (three ? mesh_hops(i, int'(fin)) : 0);
            if (mask[i]) sharers++;
        end
        // ascending id when multicast or a lone sharer, else by key then id
        if (mcast || sharers <= 1) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
                if (mask[i]) begin
                    order[placed] = i;
                    placed++;
                end
            end
        end else begin
            for (int k = 0; k < 64; k++) begin
                for (int i = 0; i < NODE_COUNT; i++) begin
                    if (mask[i] && node_key[i] == k) begin
                        order[placed] = i;
                        placed++;
                    end
                end
            end
        end
        for (int i = 0; i < placed; i++) begin
            s.node_id = NODE_W'(order[i]);
            s.last    = (i == placed - 1);
            owed_buf[owed_tail % OWED_DEPTH] = s;
            owed_tail++;
        end
    endtask

    // compare each snoop with the oldest one owed, then record new requests
    always @(posedge i_clk) begin
        t_snoop want;
        if (!i_rst_n) begin
            owed_head = 0;
            owed_tail = 0;
            o_fail_count <= 0;
        end else begin
            if (i_snp_valid && i_snp_ready) begin
                if (owed_tail == owed_head) begin
                    $display("%0t snoop with none owed: got node %0d last %0d",
                             $time, i_snp_node_id, i_snp_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = owed_buf[owed_head % OWED_DEPTH];
                    owed_head++;
                    if (want.node_id !== i_snp_node_id || want.last !== i_snp_last) begin
                        if (want.node_id !== i_snp_node_id)
                            $display("%0t node_id mismatch: expected %0d, got %0d",
                                     $time, want.node_id, i_snp_node_id);
                        if (want.last !== i_snp_last)
                            $display("%0t last mismatch: expected %0d, got %0d",
                                     $time, want.last, i_snp_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_snoop_order(i_req_sharer_mask, i_req_source_node, i_req_final_node,
                                    i_req_three_hop_mode, i_req_multicast_mode);
            end
        end
        o_pending <= owed_tail - owed_head;
    end

endmodule

>>> tb/sv/tb_snoop_order_by_mesh_distance_unit.sv
// testbench top: request stimulus, result back-pressure and verdict
module tb_snoop_order_by_mesh_distance_unit import sodist_pkg::*; ();

    localparam int MESH_WIDTH  = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 120;

    logic i_clk;
    logic i_rst_n;
    logic snp_ready = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    sodist_req_if req_if ();
    sodist_snp_if snp_if ();

    assign snp_if.ready = snp_ready;

    snoop_order_by_mesh_distance_unit #(.MESH_WIDTH(MESH_WIDTH)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_snp  (snp_if)
    );

    snoop_order_checker #(.MESH_WIDTH(MESH_WIDTH)) u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (req_if.valid),
        .i_req_ready         (req_if.ready),
        .i_req_sharer_mask   (req_if.sharer_mask),
        .i_req_source_node   (req_if.source_node),
        .i_req_final_node    (req_if.final_node),
        .i_req_three_hop_mode(req_if.three_hop_mode),
        .i_req_multicast_mode(req_if.multicast_mode),
        .i_snp_valid         (snp_if.valid),
        .i_snp_ready         (snp_if.ready),
        .i_snp_node_id       (snp_if.node_id),
        .i_snp_last          (snp_if.last),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snp_ready <= 1'b0;
        end else begin
            snp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // present one request and hold it until the request channel takes it
    task automatic send_request(input logic [NODE_COUNT-1:0] mask,
                                input logic [NODE_W-1:0] src,
                                input logic [NODE_W-1:0] fin,
                                input logic three,
                                input logic mcast);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.sharer_mask    <= mask;
        req_if.source_node    <= src;
        req_if.final_node     <= fin;
        req_if.three_hop_mode <= three;
        req_if.multicast_mode <= mcast;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // drop valid and hold off until every owed snoop has come back
    task automatic drain_snoops();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // random sharer mask: mostly dense, some sparse, a few empty or full
    function automatic logic [NODE_COUNT-1:0] pick_mask();
        int sel;
        logic [NODE_COUNT-1:0] m;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            m = '0;
        end else if (sel < 30) begin
            m = '0;
            for (int i = $urandom_range(1, 3); i > 0; i--) m[$urandom_range(0, 15)] = 1'b1;
        end else if (sel < 40) begin
            m = '1;
            if ($urandom_range(0, 1)) m[$urandom_range(0, 15)] = 1'b0;
        end else begin
            m = NODE_COUNT'($urandom);
        end
        return m;
    endfunction

    initial begin
        i_rst_n               <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.sharer_mask    <= '0;
        req_if.source_node    <= '0;
        req_if.final_node     <= '0;
        req_if.three_hop_mode <= 1'b0;
        req_if.multicast_mode <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, lone sharer, full mesh, corners, ties and both modes
        send_request(16'h0000, 4'd0,  4'd0,  1'b0, 1'b0);
        send_request(16'h0000, 4'd15, 4'd15, 1'b1, 1'b1);
        send_request(16'h0001, 4'd15, 4'd0,  1'b0, 1'b0);
        send_request(16'h8000, 4'd0,  4'd15, 1'b1, 1'b0);
        send_request(16'h0400, 4'd0,  4'd15, 1'b1, 1'b0);
        send_request(16'hFFFF, 4'd0,  4'd0,  1'b0, 1'b0);
        send_request(16'hFFFF, 4'd15, 4'd0,  1'b0, 1'b0);
        send_request(16'hFFFF, 4'd5,  4'd10, 1'b1, 1'b0);
        send_request(16'hFFFF, 4'd0,  4'd15, 1'b1, 1'b0);
        send_request(16'hFFFF, 4'd15, 4'd0,  1'b0, 1'b1);
        send_request(16'hFFFF, 4'd9,  4'd6,  1'b1, 1'b1);
        send_request(16'h8421, 4'd0,  4'd15, 1'b1, 1'b0);
        send_request(16'h1248, 4'd15, 4'd0,  1'b0, 1'b0);
        send_request(16'hA5A5, 4'd6,  4'd6,  1'b0, 1'b0);
        send_request(16'h5A5A, 4'd9,  4'd3,  1'b1, 1'b0);
        send_request(16'h0C30, 4'd5,  4'd5,  1'b0, 1'b0);
        send_request(16'h0011, 4'd0,  4'd12, 1'b1, 1'b0);
        send_request(16'h8001, 4'd10, 4'd5,  1'b0, 1'b1);
        drain_snoops();

        // random phases: free running, idle sender, stalled receiver, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(pick_mask(), NODE_W'($urandom_range(0, 15)),
                             NODE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                             ($urandom_range(0, 3) == 0));
            end
            drain_snoops();
        end

        // tail: let any stray snoop show up before the verdict
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
